// ----- hdl/icymd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package icymd_pkg;

  // Framing counters
  localparam int unsigned COUNT_BITS  = 20;
  localparam int unsigned INTERVAL_W  = 20;
  localparam int unsigned CMP_W       = (COUNT_BITS > INTERVAL_W) ? COUNT_BITS : INTERVAL_W;
  localparam int unsigned REMAIN_W    = 12;

  // Title capture
  localparam int unsigned TITLE_MAX   = 1023;
  localparam int unsigned TITLE_W     = 10;
  localparam int unsigned PREFIX_LEN  = 13;
  localparam int unsigned PREFIX_W    = 4;

  localparam logic [7:0] CHAR_QUOTE   = 8'h27;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // Byte classes as reported on the result stream
  typedef enum logic [1:0] {
    CLASS_AUDIO = 2'd0,
    CLASS_LEN   = 2'd1,
    CLASS_META  = 2'd2,
    CLASS_TITLE = 2'd3
  } byte_class_e;

  typedef enum logic {
    PH_AUDIO = 1'b0,
    PH_META  = 1'b1
  } phase_e;

  typedef enum logic [1:0] {
    CAP_MATCH = 2'd0,
    CAP_TITLE = 2'd1,
    CAP_IDLE  = 2'd2
  } capture_e;

  // Framing -> title tracker
  typedef struct packed {
    logic start;   // accepted nonzero length byte: a block opens
    logic step;    // accepted byte inside a block
    logic last;    // that byte closes the block
  } cap_ctrl_t;

  // Title tracker -> framing
  typedef struct packed {
    logic               title_char;
    logic               done;
    logic [TITLE_W-1:0] length;
  } cap_stat_t;

  // Characters of the text StreamTitle='
  function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6C; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3D; // =
      4'd12:   c = 8'h27; // quote
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/icymd_title_track.sv -----
`timescale 1ns / 1ps
`default_nettype none

module icymd_title_track
  import icymd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cap_ctrl_t  ctrl_i,
  input  wire logic [7:0] byte_i,
  output cap_stat_t       stat_o
);

  capture_e             cap_q, cap_d;
  logic [PREFIX_W-1:0]  idx_q, idx_d;
  logic [TITLE_W-1:0]   cnt_q, cnt_d;
  logic                 ending;

  always_comb begin
    cap_d             = cap_q;
    idx_d             = idx_q;
    cnt_d             = cnt_q;
    ending            = 1'b0;
    stat_o.title_char = 1'b0;
    stat_o.done       = 1'b0;
    stat_o.length     = '0;
    if (ctrl_i.start) begin
      cap_d = CAP_MATCH;
      idx_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      case (cap_q)
        CAP_MATCH: begin
          if ((idx_q < PREFIX_W'(PREFIX_LEN)) && (byte_i == prefix_char(idx_q))) begin
            idx_d = idx_q + 1'b1;
            if (idx_d >= PREFIX_W'(PREFIX_LEN)) begin
              cap_d = CAP_TITLE;
              cnt_d = '0;
            end
          end else begin
            cap_d = CAP_IDLE;
          end
        end
        CAP_TITLE: begin
          if ((byte_i == CHAR_QUOTE) || (byte_i == CHAR_NUL)) begin
            ending = 1'b1;
          end else if (cnt_q < TITLE_W'(TITLE_MAX)) begin
            cnt_d             = cnt_q + 1'b1;
            stat_o.title_char = 1'b1;
          end
          // a character on the closing byte is counted before the end
          if (ctrl_i.last) begin
            ending = 1'b1;
          end
          if (ending) begin
            cap_d = CAP_IDLE;
            if (cnt_d != '0) begin
              stat_o.done   = 1'b1;
              stat_o.length = cnt_d;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_MATCH;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      cap_q <= cap_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/icy_metadata_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel     | Dir | Signals                         | Contents
// ------------+-----+---------------------------------+------------------------------------
// s_axis      | in  | tvalid, tready, tdata[7:0]      | stream_byte
// m_axis      | out | tvalid, tready, tdata[23:0],    | byte_out, title_done, title_length;
//             |     | tuser[1:0], tlast               | byte_class; block_last
// cfg         | in  | we, wdata[19:0]                 | meta_interval
//
// One byte per cycle while the sink takes results: each byte is classed in the
// cycle of its transfer and its result is loaded into the output register.
// Framing counters and the prefix compare settle in the cycle of the transfer.
// Reset returns to the audio phase with zero counters and interval zero.
// The input is stalled only while the output register holds a result that
// the sink has not taken.

module icy_metadata_deframer
  import icymd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [7:0]            s_axis_tdata_i,   // [7:0] stream_byte
  // result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [23:0]                m_axis_tdata_o,   // [7:0] byte_out, [8] title_done,
                                                       // [18:9] title_length, rest zero
  output logic [1:0]                 m_axis_tuser_o,   // [1:0] byte_class
  output logic                       m_axis_tlast_o,   // block_last
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [INTERVAL_W-1:0] cfg_wdata_i       // meta_interval
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  accept;
  logic [INTERVAL_W-1:0] interval_q;
  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] audio_q, audio_d;
  logic [REMAIN_W-1:0]   remain_q, remain_d;

  byte_class_e           cls;
  logic                  last;
  cap_ctrl_t             cap_ctrl;
  cap_stat_t             cap_stat;

  logic                  m_valid_q;
  byte_class_e           cls_q;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic                  done_q;
  logic [TITLE_W-1:0]    len_q;

  // Take a new byte whenever the output register is free or being drained.
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Framing: count audio, spot the length byte, count down the block.
  always_comb begin
    phase_d        = phase_q;
    audio_d        = audio_q;
    remain_d       = remain_q;
    cls            = CLASS_AUDIO;
    last           = 1'b0;
    cap_ctrl.start = 1'b0;
    cap_ctrl.step  = 1'b0;
    cap_ctrl.last  = 1'b0;
    if (phase_q == PH_META) begin
      last          = (remain_q <= REMAIN_W'(1));
      cls           = cap_stat.title_char ? CLASS_TITLE : CLASS_META;
      cap_ctrl.step = accept;
      cap_ctrl.last = last;
      if (accept) begin
        if (last) begin
          phase_d  = PH_AUDIO;
          remain_d = '0;
          audio_d  = '0;
        end else begin
          remain_d = remain_q - 1'b1;
        end
      end
    end else if ((interval_q != '0) && (CMP_W'(audio_q) >= CMP_W'(interval_q))) begin
      // length byte: block of length*16 bytes, or none at all for zero
      cls = CLASS_LEN;
      if (s_axis_tdata_i == 8'h00) begin
        last = 1'b1;
      end
      if (accept) begin
        audio_d = '0;
        if (s_axis_tdata_i != 8'h00) begin
          phase_d        = PH_META;
          remain_d       = {s_axis_tdata_i, 4'h0};
          cap_ctrl.start = 1'b1;
        end
      end
    end else begin
      // audio: saturate the count rather than wrap
      if (accept && (audio_q != COUNT_MAX)) begin
        audio_d = audio_q + 1'b1;
      end
    end
  end

  icymd_title_track u_title (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cap_ctrl),
    .byte_i (s_axis_tdata_i),
    .stat_o (cap_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      phase_q    <= PH_AUDIO;
      audio_q    <= '0;
      remain_q   <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      audio_q  <= audio_d;
      remain_q <= remain_d;
      // hold the result until transferred, refill on the same edge
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: loaded on each input transfer, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q  <= cls;
      byte_q <= s_axis_tdata_i;
      last_q <= last;
      done_q <= cap_stat.done;
      len_q  <= cap_stat.length;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = cls_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {5'b0, len_q, done_q, byte_q};

endmodule

`default_nettype wire

// ----- tb/tb_icy_metadata_deframer.sv -----
`timescale 1ns / 1ps

module tb_icy_metadata_deframer;
  import icymd_pkg::*;

  // Text that opens a metadata block carrying a title, first character in the top byte
  localparam logic [8*PREFIX_LEN-1:0] TITLE_TAG = "StreamTitle='";

  typedef struct packed {
    byte_class_e        cls;
    logic [7:0]         data;
    logic               last;
    logic               done;
    logic [TITLE_W-1:0] tlen;
  } byte_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic [7:0]            s_axis_tdata_i  = 8'h00;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [INTERVAL_W-1:0] cfg_wdata_i     = '0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [23:0]           m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  icy_metadata_deframer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Deframer model: its own copy of the interval and the framing/capture state
  // ---------------------------------------------------------------------------
  logic [INTERVAL_W-1:0] interval_q = '0;
  logic [COUNT_BITS-1:0] audio_cnt  = '0;
  phase_e                ph         = PH_AUDIO;
  logic [REMAIN_W-1:0]   meta_left  = '0;
  logic [PREFIX_W-1:0]   tag_pos    = '0;
  capture_e              cap        = CAP_MATCH;
  logic [TITLE_W-1:0]    title_cnt  = '0;

  byte_result_t classified_q [$];   // expected results, oldest first
  logic [7:0]   stream_q [$];       // bytes waiting to be sent
  int           mismatches = 0;

  function automatic logic [7:0] tag_char(input int i);
    return TITLE_TAG[8*(PREFIX_LEN-1-i) +: 8];
  endfunction

  // Class one accepted byte and advance the model state.
  function automatic byte_result_t classify_byte(input logic [7:0] b);
    byte_result_t r;
    logic         ending;
    r      = '0;
    r.data = b;
    ending = 1'b0;
    if (ph == PH_META) begin
      r.last = (meta_left <= 1);
      r.cls  = CLASS_META;
      case (cap)
        CAP_MATCH: begin
          if (tag_pos < PREFIX_LEN && b == tag_char(tag_pos)) begin
            tag_pos++;
            if (tag_pos == PREFIX_LEN) begin
              cap       = CAP_TITLE;
              title_cnt = '0;
            end
          end else begin
            cap = CAP_IDLE;
          end
        end
        CAP_TITLE: begin
          // quote or NUL closes the title; beyond the limit, drop the character
          if (b == CHAR_QUOTE || b == CHAR_NUL) begin
            ending = 1'b1;
          end else if (title_cnt < TITLE_MAX) begin
            title_cnt++;
            r.cls = CLASS_TITLE;
          end
          if (r.last) ending = 1'b1;
        end
        default: ;
      endcase
      if (ending) begin
        if (title_cnt != 0) begin
          r.done = 1'b1;
          r.tlen = title_cnt;
        end
        cap = CAP_IDLE;
      end
      if (r.last) begin
        ph        = PH_AUDIO;
        meta_left = '0;
        audio_cnt = '0;
      end else begin
        meta_left = meta_left - 1'b1;
      end
    end else if (interval_q != 0 && audio_cnt >= interval_q) begin
      r.cls     = CLASS_LEN;
      audio_cnt = '0;
      if (b == 8'h00) begin
        r.last = 1'b1;
      end else begin
        ph        = PH_META;
        meta_left = {b, 4'b0000};
        tag_pos   = '0;
        cap       = CAP_MATCH;
        title_cnt = '0;
      end
    end else begin
      r.cls = CLASS_AUDIO;
      if (audio_cnt != {COUNT_BITS{1'b1}}) audio_cnt++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps, hold-off on request
  // ---------------------------------------------------------------------------
  bit sender_hold = 1'b0;
  int burst_left  = 4;
  int gap_left    = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        classified_q.push_back(classify_byte(s_axis_tdata_i));
        void'(stream_q.pop_front());
      end
      // only move on once the current transfer is done
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (sender_hold || stream_q.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= stream_q[0];
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall pattern reloaded when its age runs out; transfers are
  // registered, then compared, so every byte that could have caused one is predicted
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age   = 0;
  logic        seen_valid = 1'b0;
  logic [23:0] seen_tdata = '0;
  logic [1:0]  seen_tuser = '0;
  logic        seen_tlast = 1'b0;

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    byte_result_t want;
    if (seen_valid) begin
      if (classified_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual 0x%h %0d %b",
                 $time, seen_tdata, seen_tuser, seen_tlast);
        mismatches++;
      end else begin
        want = classified_q.pop_front();
        check_field("byte_class", want.cls, seen_tuser);
        check_field("byte_out", want.data, seen_tdata[7:0]);
        check_field("block_last", want.last, seen_tlast);
        check_field("title_done", want.done, seen_tdata[8]);
        check_field("title_length", want.tlen, seen_tdata[18:9]);
        check_field("tdata padding", 0, seen_tdata[23:19]);
      end
    end
    seen_valid <= rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    seen_tdata <= m_axis_tdata_o;
    seen_tuser <= m_axis_tuser_o;
    seen_tlast <= m_axis_tlast_o;

    if (pat_age == 0) begin
      pat_age = 48;
      case ($urandom_range(0, 3))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom);
        2:       stall_pat = 16'($urandom | $urandom);
        default: stall_pat = 16'($urandom & $urandom);
      endcase
    end
    pat_age--;
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    m_axis_tready_i <= stall_pat[0];
  end

  // ---------------------------------------------------------------------------
  // Stimulus: byte sequences framed to match the interval in force
  // ---------------------------------------------------------------------------
  int gen_audio = 0;   // audio bytes queued since the last length byte

  task automatic feed_audio(input logic [7:0] b);
    stream_q.push_back(b);
    gen_audio++;
  endtask

  task automatic push_audio(input int n);
    int i;
    for (i = 0; i < n; i++) feed_audio(8'($urandom_range(0, 255)));
  endtask

  // Wait until every expected result has arrived; with_queue also waits for
  // the pending bytes to be sent.
  task automatic wait_results(input bit with_queue);
    while ((with_queue && stream_q.size() != 0) || s_axis_tvalid_i ||
           classified_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Write the interval while the block is idle.
  task automatic set_interval(input logic [INTERVAL_W-1:0] v);
    wait_results(1'b1);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    interval_q = v;
  endtask

  // Remaining audio, the length byte, then the block body. Most bodies open
  // with the title tag; some break the tag, some carry an empty title, some
  // are plain noise.
  task automatic push_frame(input logic [7:0] len, input bit long_title);
    logic [7:0] body [$];
    logic [7:0] c;
    int         n, i, kind, k, tl;
    push_audio((interval_q > gen_audio) ? int'(interval_q) - gen_audio : 0);
    stream_q.push_back(len);
    gen_audio = 0;
    if (len != 0) begin
      n = 16 * int'(len);
      for (i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
      kind = long_title ? 10 : $urandom_range(0, 19);
      if (kind < 15) begin
        k = (kind < 3) ? $urandom_range(0, PREFIX_LEN - 1) : PREFIX_LEN;
        for (i = 0; i < k; i++) body[i] = tag_char(i);
        if (k < PREFIX_LEN) begin
          body[k] = tag_char(k) ^ (8'h01 << $urandom_range(0, 7));
        end else begin
          if (long_title) tl = n - PREFIX_LEN;
          else tl = (kind < 5) ? 0 : $urandom_range(1, n - PREFIX_LEN);
          for (i = PREFIX_LEN; i < PREFIX_LEN + tl; i++) begin
            do c = 8'($urandom_range(1, 255)); while (c == CHAR_QUOTE);
            body[i] = c;
          end
          if (PREFIX_LEN + tl < n) begin
            case ($urandom_range(0, 2))
              0:       body[PREFIX_LEN + tl] = CHAR_QUOTE;
              1:       body[PREFIX_LEN + tl] = CHAR_NUL;
              default: ;
            endcase
          end
        end
      end
      foreach (body[i]) stream_q.push_back(body[i]);
    end
  endtask

  task automatic run_frames(input int budget);
    int sent, r;
    logic [7:0] len;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 19);
      if (r < 2) len = 8'd0;
      else if (r < 17) len = 8'd1;
      else if (r < 19) len = 8'($urandom_range(2, 3));
      else len = 8'($urandom_range(4, 8));
      push_frame(len, 1'b0);
      sent += int'(interval_q) + 1 + 16 * int'(len);
    end
    push_audio($urandom_range(0, int'(interval_q) - 1));
  endtask

  initial begin
    int i;
    int half;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: interval zero passes everything as audio
    feed_audio(8'h00);
    feed_audio(8'hFF);
    feed_audio(CHAR_QUOTE);
    feed_audio(tag_char(0));

    // Interval one: the carried audio count opens a length byte at once.
    // Zero length, one audio byte, then a one-character title closed by a quote.
    set_interval(20'd1);
    stream_q.push_back(8'h00);
    feed_audio(8'hAA);
    stream_q.push_back(8'h01);
    for (i = 0; i < PREFIX_LEN; i++) stream_q.push_back(tag_char(i));
    stream_q.push_back(8'h41);
    stream_q.push_back(CHAR_QUOTE);
    stream_q.push_back(CHAR_NUL);
    gen_audio = 0;

    // Random framed traffic over several intervals
    set_interval(20'd2);
    run_frames(40);
    // let part of the traffic through, then hold the sender with bytes
    // still queued until the output has caught up
    half = stream_q.size() / 2;
    while (stream_q.size() > half) @(posedge clk_i);
    sender_hold = 1'b1;
    wait_results(1'b0);
    sender_hold = 1'b0;
    run_frames(40);

    set_interval(20'd7);
    run_frames(60);

    set_interval(20'd0);
    push_audio(20);

    // lowered interval: the audio count already exceeds it
    set_interval(20'd1);
    run_frames(50);

    set_interval({INTERVAL_W{1'b1}});
    push_audio(20);

    set_interval(20'd3);
    run_frames(50);

    // title that runs to the end of the block, a character on the last byte
    set_interval(20'd33);
    push_frame(8'd4, 1'b1);
    run_frames(30);

    wait_results(1'b1);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/icymd_pkg.sv
hdl/icymd_title_track.sv
hdl/icy_metadata_deframer.sv
tb/tb_icy_metadata_deframer.sv
